>>> src/i2csw_pkg.sv
// shared types and constants for the i2c slave write receiver
package i2csw_pkg;

  localparam int ADDR_W      = 7;
  localparam int FRAME_W     = 4;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int BIT_CNT_W   = 4;
  localparam int BYTE_W      = 8;

  localparam logic [ADDR_W-1:0]  OWN_ADDRESS_RST = 7'h55;
  localparam logic [FRAME_W-1:0] FRAME_BYTES_RST = 4'd8;
  localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BYTES = 1'b1;

  // event kinds
  localparam logic KIND_SDA_FALL = 1'b0;
  localparam logic KIND_SCL_RISE = 1'b1;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_ADDR     = 5'b00010,
    PH_ADDR_ACK = 5'b00100,
    PH_DATA     = 5'b01000,
    PH_DATA_ACK = 5'b10000
  } phase_t;

  typedef struct packed {
    logic kind;
    logic sda_level;
    logic scl_level;
  } in_word_t;

  typedef struct packed {
    logic               sda_pull_low;
    logic               address_matched;
    logic               byte_valid;
    logic [BYTE_W-1:0]  data_byte;
    logic [FRAME_W-1:0] byte_index;
    logic               last_byte;
  } out_word_t;

endpackage

>>> src/i2csw_core.sv
// bus event state machine: address match, byte assembly, acknowledge control
module i2csw_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [i2csw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [i2csw_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                evt_accept,
  input  i2csw_pkg::in_word_t                 evt_word,
  output i2csw_pkg::out_word_t                res_word
);

  logic [i2csw_pkg::ADDR_W-1:0]    own_address_r;
  logic [i2csw_pkg::FRAME_W-1:0]   frame_bytes_r;

  i2csw_pkg::phase_t               phase_r, phase_nxt;
  logic [i2csw_pkg::BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [i2csw_pkg::BYTE_W-1:0]    shift_r, shift_nxt;
  logic [i2csw_pkg::FRAME_W-1:0]   bytes_r, bytes_nxt;
  logic                            ack_r, ack_nxt;

  logic [i2csw_pkg::BYTE_W-1:0]    shifted;
  logic [i2csw_pkg::BIT_CNT_W-1:0] cnt_inc;
  logic [i2csw_pkg::FRAME_W-1:0]   bytes_inc;
  logic [i2csw_pkg::FRAME_W-1:0]   frame_limit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= i2csw_pkg::OWN_ADDRESS_RST;
      frame_bytes_r <= i2csw_pkg::FRAME_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        i2csw_pkg::CFG_OWN_ADDRESS: own_address_r <= cfg_data;
        i2csw_pkg::CFG_FRAME_BYTES: frame_bytes_r <= cfg_data[i2csw_pkg::FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  assign shifted   = {shift_r[i2csw_pkg::BYTE_W-2:0], evt_word.sda_level};
  assign cnt_inc   = bit_cnt_r + 1'b1;
  assign bytes_inc = bytes_r + 1'b1;
  // zero frame length counts as one
  assign frame_limit = (frame_bytes_r == '0) ? {{(i2csw_pkg::FRAME_W-1){1'b0}}, 1'b1}
                                             : frame_bytes_r;

  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    bytes_nxt   = bytes_r;
    ack_nxt     = ack_r;
    res_word    = '0;

    if (evt_word.kind == i2csw_pkg::KIND_SDA_FALL) begin
      // start condition only seen while idle
      if (phase_r == i2csw_pkg::PH_IDLE && evt_word.scl_level && !evt_word.sda_level) begin
        phase_nxt   = i2csw_pkg::PH_ADDR;
        bit_cnt_nxt = '0;
        shift_nxt   = '0;
        bytes_nxt   = '0;
        ack_nxt     = 1'b0;
      end
    end else begin
      case (phase_r)
        i2csw_pkg::PH_ADDR: begin
          shift_nxt   = shifted;
          bit_cnt_nxt = cnt_inc;
          if (cnt_inc >= i2csw_pkg::BITS_PER_BYTE) begin
            bit_cnt_nxt = '0;
            shift_nxt   = '0;
            if (shifted[i2csw_pkg::BYTE_W-1:1] == own_address_r) begin
              res_word.address_matched = 1'b1;
              ack_nxt   = 1'b1;
              phase_nxt = i2csw_pkg::PH_ADDR_ACK;
            end else begin
              bytes_nxt = '0;
              ack_nxt   = 1'b0;
              phase_nxt = i2csw_pkg::PH_IDLE;
            end
          end
        end
        i2csw_pkg::PH_ADDR_ACK: begin
          ack_nxt     = 1'b0;
          bit_cnt_nxt = '0;
          shift_nxt   = '0;
          phase_nxt   = i2csw_pkg::PH_DATA;
        end
        i2csw_pkg::PH_DATA: begin
          shift_nxt   = shifted;
          bit_cnt_nxt = cnt_inc;
          if (cnt_inc >= i2csw_pkg::BITS_PER_BYTE) begin
            res_word.byte_valid = 1'b1;
            res_word.data_byte  = shifted;
            res_word.byte_index = bytes_r;
            res_word.last_byte  = (bytes_inc >= frame_limit);
            bytes_nxt   = bytes_inc;
            ack_nxt     = 1'b1;
            bit_cnt_nxt = '0;
            shift_nxt   = '0;
            phase_nxt   = i2csw_pkg::PH_DATA_ACK;
          end
        end
        i2csw_pkg::PH_DATA_ACK: begin
          ack_nxt     = 1'b0;
          bit_cnt_nxt = '0;
          shift_nxt   = '0;
          if (bytes_r >= frame_limit) begin
            bytes_nxt = '0;
            phase_nxt = i2csw_pkg::PH_IDLE;
          end else begin
            phase_nxt = i2csw_pkg::PH_DATA;
          end
        end
        default: ;
      endcase
    end

    res_word.sda_pull_low = ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= i2csw_pkg::PH_IDLE;
      bit_cnt_r <= '0;
      shift_r   <= '0;
      bytes_r   <= '0;
      ack_r     <= 1'b0;
    end else if (evt_accept) begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      bytes_r   <= bytes_nxt;
      ack_r     <= ack_nxt;
    end
  end

endmodule

>>> src/i2csw_out_reg.sv
// result register between the state machine and the output channel
module i2csw_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  i2csw_pkg::out_word_t  load_word,
  input  logic                  out_stall,
  output logic                  out_valid,
  output i2csw_pkg::out_word_t  out_data,
  output logic                  full_stalled
);

  logic                 valid_r;
  i2csw_pkg::out_word_t word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= load_word;
    end
  end

  assign out_valid    = valid_r;
  assign out_data     = word_r;
  // a new word can enter whenever the held one leaves this cycle
  assign full_stalled = valid_r && out_stall;

endmodule

>>> src/i2c_slave_write_receiver.sv
// top level of the i2c slave write receiver
//
//   channel | direction | word type   | handshake
//   in_     | input     | in_word_t   | in_valid / in_stall
//   out_    | output    | out_word_t  | out_valid / out_stall
//   cfg_    | input     | index, data | cfg_we, no wait
//
// one event accepted per cycle unless stalled; its word sits in the result
// register the cycle after. the state update is one pass of the event
// state machine. in_stall is high only while a result is held and out_stall
// is high. rst_n is synchronous: state goes idle, config registers reset.
module i2c_slave_write_receiver (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [i2csw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2csw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  i2csw_pkg::in_word_t               in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output i2csw_pkg::out_word_t              out_data
);

  logic                 accept;
  logic                 full_stalled;
  i2csw_pkg::out_word_t res_word;

  assign in_stall = full_stalled;
  assign accept   = in_valid && !full_stalled;

  i2csw_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .evt_accept (accept),
    .evt_word   (in_data),
    .res_word   (res_word)
  );

  i2csw_out_reg u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (accept),
    .load_word    (res_word),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .full_stalled (full_stalled)
  );

endmodule

>>> src/i2csw_checker.sv
// port level checks for the i2c slave write receiver, bound to the top level
module i2csw_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input i2csw_pkg::out_word_t              out_data
);

  // a held word stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // input back-pressure only comes from a held, stalled result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // every accepted event yields a word next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted event produced no word");

  // address match and data byte complete on different clocks, both acknowledge
  a_ack_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.address_matched || out_data.byte_valid) |->
      out_data.sda_pull_low && !(out_data.address_matched && out_data.byte_valid))
    else $error("completion without acknowledge");

  // byte fields are zero when no byte is presented
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |->
      out_data.data_byte == '0 && out_data.byte_index == '0 && !out_data.last_byte)
    else $error("byte fields set without byte_valid");

endmodule

bind i2c_slave_write_receiver i2csw_checker u_i2csw_checker (.*);
